// ===== hw/rtl/crfw_pkg.sv =====
package crfw_pkg;

    localparam int ADDR_W     = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SURF_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURF_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FMT_OK = 2'd3;

    localparam logic [1:0] PIX_SINGLE = 2'd1;
    localparam logic [1:0] PIX_PAIR   = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [15:0] rect_w;
        logic [15:0] rect_h;
        logic [15:0] fill_value;
    } t_in_word;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_addr;
        logic [1:0]        write_pixels;
        logic [31:0]       write_data;
        logic              last_write;
        logic              busy_res;
    } t_out_word;

    typedef struct packed {
        logic [12:0] surf_w;
        logic [12:0] surf_h;
        logic [13:0] pitch;
        logic        fmt_ok;
    } t_cfg;

endpackage

// ===== hw/rtl/crfw_cfg_regs.sv =====
module crfw_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wen,
    input  logic [crfw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [crfw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output crfw_pkg::t_cfg                     o_cfg
);

    crfw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.surf_w <= '0;
            r_cfg.surf_h <= '0;
            r_cfg.pitch  <= '0;
            r_cfg.fmt_ok <= 1'b1;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                crfw_pkg::CFG_SURF_W: r_cfg.surf_w <= i_cfg_data[12:0];
                crfw_pkg::CFG_SURF_H: r_cfg.surf_h <= i_cfg_data[12:0];
                crfw_pkg::CFG_PITCH:  r_cfg.pitch  <= i_cfg_data[13:0];
                crfw_pkg::CFG_FMT_OK: r_cfg.fmt_ok <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/crfw_walker.sv =====
module crfw_walker #(
    parameter int MAX_DIM = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crfw_pkg::t_cfg      i_cfg,
    input  logic                i_fire,
    input  crfw_pkg::t_in_word  i_word,
    output crfw_pkg::t_out_word o_result
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int AW    = crfw_pkg::ADDR_W;

    logic             r_active;
    logic [DIM_W-1:0] r_col_pos;
    logic [DIM_W-1:0] r_row_pos;
    logic [DIM_W-1:0] r_col_start;
    logic [DIM_W-1:0] r_col_end;
    logic [DIM_W-1:0] r_row_end;
    logic [AW-1:0]    r_row_base;
    logic [15:0]      r_held;

    logic             n_active;
    logic [DIM_W-1:0] n_col_pos;
    logic [DIM_W-1:0] n_row_pos;
    logic [DIM_W-1:0] n_col_start;
    logic [DIM_W-1:0] n_col_end;
    logic [DIM_W-1:0] n_row_end;
    logic [AW-1:0]    n_row_base;
    logic [15:0]      n_held;

    // clip
    logic [DIM_W-1:0]  wb;
    logic [DIM_W-1:0]  hb;
    logic signed [17:0] x0;
    logic signed [17:0] y0;
    logic signed [17:0] x2;
    logic signed [17:0] y2;
    logic signed [17:0] xc;
    logic signed [17:0] yc;
    logic signed [17:0] x2c;
    logic signed [17:0] y2c;
    logic               start_ok;

    // step
    logic [DIM_W:0] col_inc1;
    logic           single;
    logic [DIM_W:0] col_nxt;
    logic           row_wrap;
    logic [DIM_W:0] row_inc;
    logic           fill_done;

    always_comb begin
        wb = (32'(i_cfg.surf_w) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(i_cfg.surf_w);
        hb = (32'(i_cfg.surf_h) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(i_cfg.surf_h);
        x0 = 18'(i_word.rect_x);
        y0 = 18'(i_word.rect_y);
        x2 = x0 + signed'({2'b00, i_word.rect_w});
        y2 = y0 + signed'({2'b00, i_word.rect_h});
        xc  = (x0 < 0) ? '0 : x0;
        yc  = (y0 < 0) ? '0 : y0;
        x2c = (x2 > signed'(18'(wb))) ? signed'(18'(wb)) : x2;
        y2c = (y2 > signed'(18'(hb))) ? signed'(18'(hb)) : y2;
        start_ok = i_cfg.fmt_ok && (x2c > xc) && (y2c > yc);
    end

    always_comb begin
        col_inc1  = {1'b0, r_col_pos} + (DIM_W+1)'(1);
        single    = r_col_pos[0] || (col_inc1 >= {1'b0, r_col_end});
        col_nxt   = {1'b0, r_col_pos} + (single ? (DIM_W+1)'(1) : (DIM_W+1)'(2));
        row_wrap  = col_nxt >= {1'b0, r_col_end};
        row_inc   = {1'b0, r_row_pos} + (DIM_W+1)'(1);
        fill_done = row_wrap && (row_inc >= {1'b0, r_row_end});
    end

    always_comb begin
        n_active    = r_active;
        n_col_pos   = r_col_pos;
        n_row_pos   = r_row_pos;
        n_col_start = r_col_start;
        n_col_end   = r_col_end;
        n_row_end   = r_row_end;
        n_row_base  = r_row_base;
        n_held      = r_held;
        o_result    = '0;
        if (i_word.cmd == crfw_pkg::CMD_START) begin
            n_active = start_ok;
            if (start_ok) begin
                n_col_start = DIM_W'(xc);
                n_col_end   = DIM_W'(x2c);
                n_col_pos   = DIM_W'(xc);
                n_row_pos   = DIM_W'(yc);
                n_row_end   = DIM_W'(y2c);
                n_row_base  = AW'(DIM_W'(yc)) * AW'(i_cfg.pitch);
                n_held      = i_word.fill_value;
            end
        end else if (r_active) begin
            o_result.write_valid  = 1'b1;
            o_result.write_addr   = r_row_base + AW'(r_col_pos);
            o_result.write_pixels = single ? crfw_pkg::PIX_SINGLE : crfw_pkg::PIX_PAIR;
            o_result.write_data   = {r_held, r_held};
            o_result.last_write   = fill_done;
            n_col_pos = DIM_W'(col_nxt);
            if (row_wrap) begin
                n_col_pos  = r_col_start;
                n_row_pos  = DIM_W'(row_inc);
                n_row_base = r_row_base + AW'(i_cfg.pitch);
                n_active   = !fill_done;
            end
        end
        o_result.busy_res = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_fire) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_col_pos   <= n_col_pos;
            r_row_pos   <= n_row_pos;
            r_col_start <= n_col_start;
            r_col_end   <= n_col_end;
            r_row_end   <= n_row_end;
            r_row_base  <= n_row_base;
            r_held      <= n_held;
        end
    end

endmodule

// ===== hw/rtl/clipped_rect_fill_writer_top.sv =====
// clipped rectangle fill writer
// input channel: i_in_valid / o_in_ready with i_in_word. a word with cmd start
// latches and clips a rectangle and fill value; a word with cmd step asks for
// the next memory write of the fill in progress.
// output channel: o_out_valid / i_out_ready with o_out_word. every input word
// gives exactly one output word, carrying a write or none, plus busy_res.
// config port: i_cfg_wen writes i_cfg_data to register i_cfg_index at once;
// write only while the block is idle.
// path: an accepted word is held in the input register, passes the walker
// and is registered in the output register, from which its result is taken.
// throughput: one word per cycle while the receiver keeps taking, set by the
// single walker stage between the input register and the output register; the
// start path holds the one row times pitch multiply.
// stall: while the receiver holds off, the output register keeps its word,
// the input register fills behind it and then o_in_ready drops.
// reset: clears both pipeline valids and the walker, so no fill is active;
// config returns to zero sizes with format supported.
module clipped_rect_fill_writer_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  crfw_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output crfw_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_wen,
    input  logic [crfw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crfw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    crfw_pkg::t_cfg      cfg;
    crfw_pkg::t_in_word  r_in_word;
    logic                r_in_valid;
    crfw_pkg::t_out_word r_out_word;
    logic                r_out_valid;
    crfw_pkg::t_out_word result;
    logic                advance;
    logic                fire;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    crfw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    crfw_walker #(
        .MAX_DIM (MAX_DIM)
    ) u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_word   (r_in_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
        if (fire) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== hw/rtl/crfw_checker.sv =====
module crfw_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  crfw_pkg::t_out_word             o_out_word
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

    // a word with no write carries zero fields
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.write_valid |->
            o_out_word.write_addr == '0 && o_out_word.write_pixels == '0 &&
            o_out_word.write_data == '0 && !o_out_word.last_write)
        else $error("idle word has nonzero fields");

    // a write is one or two pixels of the replicated value
    a_write_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.write_valid |->
            o_out_word.write_data[31:16] == o_out_word.write_data[15:0] &&
            (o_out_word.write_pixels == crfw_pkg::PIX_SINGLE ||
             o_out_word.write_pixels == crfw_pkg::PIX_PAIR))
        else $error("malformed write");

    // final write ends the fill
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.last_write |->
            o_out_word.write_valid && !o_out_word.busy_res)
        else $error("last write with fill still busy");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind clipped_rect_fill_writer_top crfw_checker u_crfw_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int MAX_DIM     = 4096;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_MAX    = 12;
    localparam int HOLD_LEN    = 90;
    localparam int DRAIN_WAIT  = 4;
    localparam int TAIL_WAIT   = 8;
    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 72;

    localparam crfw_pkg::t_out_word OUT_IDLE = '0;
    localparam crfw_pkg::t_out_word OUT_BUSY = '{write_valid: 1'b0, write_addr: '0,
                                                 write_pixels: 2'd0, write_data: 32'd0,
                                                 last_write: 1'b0, busy_res: 1'b1};

    typedef enum logic {ROW_CFG, ROW_WORD} t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [crfw_pkg::CFG_IDX_W-1:0]  idx;
        logic [crfw_pkg::CFG_DATA_W-1:0] val;
        crfw_pkg::t_in_word              word;
        logic                            typed;
        crfw_pkg::t_out_word             want;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    crfw_pkg::t_in_word              i_in_word;
    logic                            o_out_valid;
    logic                            i_out_ready;
    crfw_pkg::t_out_word             o_out_word;
    logic                            i_cfg_wen;
    logic [crfw_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [crfw_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // shadow of the registers and the walker
    crfw_pkg::t_cfg              shadow_cfg;
    logic                        fill_on;
    int                          col_at;
    int                          col_first;
    int                          col_stop;
    int                          row_at;
    int                          row_stop;
    logic [crfw_pkg::ADDR_W-1:0] row_addr;
    logic [15:0]                 fill_px;

    crfw_pkg::t_out_word walker_words[$];
    crfw_pkg::t_out_word head_word;
    int          mismatches = 0;
    int          n_words    = 0;
    int          n_starts   = 0;
    int          n_writes   = 0;
    int          n_lasts    = 0;
    bit          send_calm  = 1'b0;
    bit          recv_calm  = 1'b0;
    int unsigned cycles     = 0;

    always #10 i_clk = ~i_clk;

    clipped_rect_fill_writer_top #(
        .MAX_DIM(MAX_DIM)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word(o_out_word),
        .i_cfg_wen(i_cfg_wen),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    function automatic crfw_pkg::t_out_word walk_fill(input crfw_pkg::t_in_word w);
        crfw_pkg::t_out_word r;
        int         x0;
        int         y0;
        int         x1;
        int         y1;
        int         xb;
        int         yb;
        logic [1:0] n;
        r = '0;
        if (w.cmd == crfw_pkg::CMD_START) begin
            x0 = $signed(w.rect_x);
            y0 = $signed(w.rect_y);
            x1 = x0 + int'(w.rect_w);
            y1 = y0 + int'(w.rect_h);
            xb = (shadow_cfg.surf_w > MAX_DIM) ? MAX_DIM : int'(shadow_cfg.surf_w);
            yb = (shadow_cfg.surf_h > MAX_DIM) ? MAX_DIM : int'(shadow_cfg.surf_h);
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > xb) x1 = xb;
            if (y1 > yb) y1 = yb;
            fill_on = 1'b0;
            if (shadow_cfg.fmt_ok && x1 > x0 && y1 > y0) begin
                fill_on   = 1'b1;
                col_first = x0;
                col_stop  = x1;
                col_at    = x0;
                row_at    = y0;
                row_stop  = y1;
                row_addr  = crfw_pkg::ADDR_W'(y0 * int'(shadow_cfg.pitch));
                fill_px   = w.fill_value;
            end
        end else if (fill_on) begin
            n = (col_at[0] || col_at + 1 >= col_stop) ? crfw_pkg::PIX_SINGLE
                                                      : crfw_pkg::PIX_PAIR;
            r.write_valid  = 1'b1;
            r.write_addr   = row_addr + crfw_pkg::ADDR_W'(col_at);
            r.write_pixels = n;
            r.write_data   = {fill_px, fill_px};
            col_at += int'(n);
            if (col_at >= col_stop) begin
                col_at   = col_first;
                row_at++;
                row_addr = row_addr + crfw_pkg::ADDR_W'(shadow_cfg.pitch);
                if (row_at >= row_stop) begin
                    fill_on      = 1'b0;
                    r.last_write = 1'b1;
                end
            end
        end
        r.busy_res = fill_on;
        return r;
    endfunction

    function automatic t_dir_row d_cfg(input logic [crfw_pkg::CFG_IDX_W-1:0] idx,
                                       input int val);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = crfw_pkg::CFG_DATA_W'(val);
        return r;
    endfunction

    function automatic t_dir_row d_start(input int x, input int y, input int w, input int h,
                                         input int v, input crfw_pkg::t_out_word want);
        t_dir_row r;
        r                 = '0;
        r.kind            = ROW_WORD;
        r.word.cmd        = crfw_pkg::CMD_START;
        r.word.rect_x     = 16'(x);
        r.word.rect_y     = 16'(y);
        r.word.rect_w     = 16'(w);
        r.word.rect_h     = 16'(h);
        r.word.fill_value = 16'(v);
        r.typed           = 1'b1;
        r.want            = want;
        return r;
    endfunction

    function automatic t_dir_row d_step(input logic typed, input crfw_pkg::t_out_word want);
        t_dir_row r;
        r          = '0;
        r.kind     = ROW_WORD;
        r.word.cmd = crfw_pkg::CMD_STEP;
        r.typed    = typed;
        r.want     = want;
        return r;
    endfunction

    function automatic crfw_pkg::t_in_word noise_word(input logic cmd);
        crfw_pkg::t_in_word w;
        w.cmd        = cmd;
        w.rect_x     = 16'($urandom);
        w.rect_y     = 16'($urandom);
        w.rect_w     = 16'($urandom);
        w.rect_h     = 16'($urandom);
        w.fill_value = 16'($urandom);
        return w;
    endfunction

    // small rectangle around the surface, sometimes hugging the far edges
    function automatic crfw_pkg::t_in_word rand_start(input int xb, input int yb);
        crfw_pkg::t_in_word w;
        int       x;
        int       y;
        w = noise_word(crfw_pkg::CMD_START);
        if ($urandom_range(0, 3) == 0) begin
            x = xb - int'($urandom_range(0, 6));
            y = yb - int'($urandom_range(0, 6));
        end else begin
            x = int'($urandom_range(0, xb + 8)) - 4;
            y = int'($urandom_range(0, yb + 8)) - 4;
        end
        w.rect_x = 16'(x);
        w.rect_y = 16'(y);
        w.rect_w = 16'($urandom_range(0, 10));
        w.rect_h = 16'($urandom_range(0, 10));
        return w;
    endfunction

    task automatic send_word(input crfw_pkg::t_in_word w, input logic typed,
                             input crfw_pkg::t_out_word want);
        int                  gap;
        crfw_pkg::t_out_word pred;
        gap = send_calm ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        pred = walk_fill(w);
        walker_words.push_back(typed ? want : pred);
        n_words++;
        if (w.cmd == crfw_pkg::CMD_START) n_starts++;
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    endtask

    task automatic cfg_write(input logic [crfw_pkg::CFG_IDX_W-1:0] idx, input int val);
        i_in_valid <= 1'b0;
        while (walker_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= crfw_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            crfw_pkg::CFG_SURF_W: shadow_cfg.surf_w = val[12:0];
            crfw_pkg::CFG_SURF_H: shadow_cfg.surf_h = val[12:0];
            crfw_pkg::CFG_PITCH:  shadow_cfg.pitch  = val[13:0];
            crfw_pkg::CFG_FMT_OK: shadow_cfg.fmt_ok = val[0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still pending", $time, walker_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (walker_words.size() == 0) begin
                mismatches++;
                $display("%0t: output word with nothing pending, got %h", $time, o_out_word);
            end else begin
                head_word = walker_words.pop_front();
                check_field("write_valid", 32'(head_word.write_valid),
                            32'(o_out_word.write_valid));
                check_field("write_addr", 32'(head_word.write_addr),
                            32'(o_out_word.write_addr));
                check_field("write_pixels", 32'(head_word.write_pixels),
                            32'(o_out_word.write_pixels));
                check_field("write_data", head_word.write_data, o_out_word.write_data);
                check_field("last_write", 32'(head_word.last_write),
                            32'(o_out_word.last_write));
                check_field("busy_res", 32'(head_word.busy_res), 32'(o_out_word.busy_res));
                if (head_word.write_valid) n_writes++;
                if (head_word.last_write) n_lasts++;
            end
        end
    end

    // receiver side, with two long hold-offs to back the block up
    initial begin : out_side
        int stall;
        int taken;
        taken = 0;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = recv_calm ? 0 : $urandom_range(0, IDLE_MAX);
            if (taken == 150 || taken == 380) stall = HOLD_LEN;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
            if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
        end
    end

    initial begin : in_side
        t_dir_row dir_tab[$];
        t_dir_row row;
        int       phase;
        int       placed;
        int       pick;
        int       lim;
        int       k;
        int       xb;
        int       yb;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_wen   <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        shadow_cfg = '{surf_w: 13'd0, surf_h: 13'd0, pitch: 14'd0, fmt_ok: 1'b1};
        fill_on    = 1'b0;
        col_at     = 0;
        col_first  = 0;
        col_stop   = 0;
        row_at     = 0;
        row_stop   = 0;
        row_addr   = '0;
        fill_px    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_tab = '{
            d_step(1'b1, OUT_IDLE),
            d_start(0, 0, 4, 2, 16'h1234, OUT_IDLE),
            d_cfg(crfw_pkg::CFG_SURF_W, 16),
            d_cfg(crfw_pkg::CFG_SURF_H, 16),
            d_cfg(crfw_pkg::CFG_PITCH, 32),
            d_start(-1, -2, 4, 4, 16'hA5C3, OUT_BUSY),
            d_step(1'b0, OUT_IDLE),
            d_step(1'b0, OUT_IDLE),
            d_step(1'b0, OUT_IDLE),
            d_step(1'b0, OUT_IDLE),
            d_step(1'b1, OUT_IDLE),
            d_start(3, 15, 65535, 65535, 16'hFFFF, OUT_BUSY),
            d_step(1'b0, OUT_IDLE),
            d_start(-32768, -32768, 0, 0, 16'h0000, OUT_IDLE),
            d_step(1'b1, OUT_IDLE),
            d_start(32767, 32767, 65535, 65535, 16'h8001, OUT_IDLE),
            d_cfg(crfw_pkg::CFG_FMT_OK, 0),
            d_start(0, 0, 2, 2, 16'h5A5A, OUT_IDLE),
            d_step(1'b1, OUT_IDLE),
            d_cfg(crfw_pkg::CFG_FMT_OK, 1),
            d_cfg(crfw_pkg::CFG_SURF_W, 8191),
            d_cfg(crfw_pkg::CFG_SURF_H, 8191),
            d_cfg(crfw_pkg::CFG_PITCH, 16383),
            d_start(4094, 4095, 65535, 65535, 16'h7E0F, OUT_BUSY),
            d_step(1'b0, OUT_IDLE),
            d_start(2046, 2048, 4, 2, 16'hC3A5, OUT_BUSY),
            d_step(1'b0, OUT_IDLE),
            d_step(1'b0, OUT_IDLE),
            d_step(1'b0, OUT_IDLE),
            d_step(1'b0, OUT_IDLE),
            d_cfg(crfw_pkg::CFG_SURF_W, 16),
            d_cfg(crfw_pkg::CFG_SURF_H, 16),
            d_cfg(crfw_pkg::CFG_PITCH, 16),
            d_start(0, 1, 2, 3, 16'h0F0F, OUT_BUSY),
            d_step(1'b0, OUT_IDLE),
            d_cfg(crfw_pkg::CFG_PITCH, 100),
            d_step(1'b0, OUT_IDLE),
            d_step(1'b0, OUT_IDLE)
        };
        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG) cfg_write(row.idx, int'(row.val));
            else send_word(row.word, row.typed, row.want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    cfg_write(crfw_pkg::CFG_SURF_W, 16);
                    cfg_write(crfw_pkg::CFG_SURF_H, 16);
                    cfg_write(crfw_pkg::CFG_PITCH, 16);
                    cfg_write(crfw_pkg::CFG_FMT_OK, 1);
                end
                1: begin
                    cfg_write(crfw_pkg::CFG_SURF_W, $urandom_range(1, 40));
                    cfg_write(crfw_pkg::CFG_SURF_H, $urandom_range(1, 40));
                    cfg_write(crfw_pkg::CFG_PITCH, $urandom_range(0, 64));
                end
                2: begin
                    cfg_write(crfw_pkg::CFG_SURF_W, 8191);
                    cfg_write(crfw_pkg::CFG_SURF_H, 8191);
                    cfg_write(crfw_pkg::CFG_PITCH, 16383);
                end
                3: begin
                    cfg_write(crfw_pkg::CFG_SURF_W, MAX_DIM);
                    cfg_write(crfw_pkg::CFG_SURF_H, 3);
                    cfg_write(crfw_pkg::CFG_PITCH, 0);
                end
                4: begin
                    cfg_write(crfw_pkg::CFG_SURF_W, 20);
                    cfg_write(crfw_pkg::CFG_FMT_OK, 0);
                end
                5: begin
                    cfg_write(crfw_pkg::CFG_SURF_W, $urandom_range(8192, 16383));
                    cfg_write(crfw_pkg::CFG_SURF_H, $urandom_range(8192, 16383));
                    cfg_write(crfw_pkg::CFG_PITCH, $urandom_range(0, 16383));
                    cfg_write(crfw_pkg::CFG_FMT_OK, $urandom_range(0, 16383));
                end
                default: begin
                    cfg_write(crfw_pkg::CFG_SURF_W, 4095);
                    cfg_write(crfw_pkg::CFG_SURF_H, 4095);
                    cfg_write(crfw_pkg::CFG_PITCH, 8191);
                    cfg_write(crfw_pkg::CFG_FMT_OK, 1);
                end
            endcase
            xb = (shadow_cfg.surf_w > MAX_DIM) ? MAX_DIM : int'(shadow_cfg.surf_w);
            yb = (shadow_cfg.surf_h > MAX_DIM) ? MAX_DIM : int'(shadow_cfg.surf_h);
            placed = 0;
            while (placed < PHASE_WORDS) begin
                pick = $urandom_range(0, 9);
                if (pick <= 6) begin
                    // full walk, now and then cut short by the next start
                    send_word(rand_start(xb, yb), 1'b0, OUT_IDLE);
                    lim = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 1 << 20;
                    k = 0;
                    while (fill_on && k < lim) begin
                        send_word(noise_word(crfw_pkg::CMD_STEP), 1'b0, OUT_IDLE);
                        k++;
                    end
                    placed += k + 1;
                end else if (pick == 7) begin
                    send_word(noise_word(crfw_pkg::CMD_START), 1'b0, OUT_IDLE);
                    placed++;
                end else begin
                    k = $urandom_range(1, 3);
                    repeat (k) send_word(noise_word(crfw_pkg::CMD_STEP), 1'b0, OUT_IDLE);
                    placed += k;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (walker_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("%0d words in (%0d fill starts), %0d memory writes and %0d fill ends checked",
                 n_words, n_starts, n_writes, n_lasts);
        $display("surfaces: empty, small, saturated, zero pitch, wrapping and disabled format");
        if (mismatches == 0 && walker_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
